>>> hw/rtl/joint_limit_fault_monitor_assert.svh
// Assertion macros shared by the joint limit fault monitor RTL.
`ifndef JOINT_LIMIT_FAULT_MONITOR_ASSERT_SVH
`define JOINT_LIMIT_FAULT_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds too.
`define JLFM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("joint limit fault monitor: implication check failed");

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define JLFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("joint limit fault monitor: next-cycle check failed");

`else

`define JLFM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define JLFM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/jlfm_pkg.sv
// Shared types, constants and helpers of the joint limit fault monitor.
package jlfm_pkg;

  localparam int JOINTS_DEF  = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JUMP_LIMIT   = 3'd0,
    REG_VEL_LIMIT    = 3'd1,
    REG_TORQUE_LIMIT = 3'd2,
    REG_SHOULDER_MIN = 3'd3,
    REG_SHOULDER_MAX = 3'd4,
    REG_ELBOW_MIN    = 3'd5,
    REG_ELBOW_MAX    = 3'd6,
    REG_COLLISION    = 3'd7
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic        [15:0] RST_JUMP_LIMIT   = 16'd3000;
  localparam logic        [14:0] RST_VEL_LIMIT    = 15'd3000;
  localparam logic        [14:0] RST_TORQUE_LIMIT = 15'd1000;
  localparam logic signed [15:0] RST_SHOULDER_MIN = -16'sd3000;
  localparam logic signed [15:0] RST_SHOULDER_MAX = 16'sd15000;
  localparam logic signed [15:0] RST_ELBOW_MIN    = 16'sd0;
  localparam logic signed [15:0] RST_ELBOW_MAX    = 16'sd14000;
  localparam logic        [15:0] RST_COLLISION    = 16'd500;

  // Fault flag bit positions
  localparam int FLAG_JUMP    = 0;
  localparam int FLAG_VEL     = 1;
  localparam int FLAG_TORQUE  = 2;
  localparam int FLAG_SOFT    = 3;
  localparam int FLAG_COLLIDE = 4;
  localparam int FLAG_W       = 5;

  // Lowest arm joint index
  localparam logic [2:0] FIRST_ARM = 3'd2;

  typedef enum logic [1:0] {
    LEVEL_NONE  = 2'd0,
    LEVEL_WARN  = 2'd1,
    LEVEL_LATCH = 2'd2,
    LEVEL_ESTOP = 2'd3
  } level_t;

  typedef struct packed {
    logic        [2:0]  joint;
    logic signed [15:0] position;
    logic signed [15:0] velocity;
    logic signed [15:0] torque;
    logic signed [7:0]  temperature;
    logic               startup_window;
    logic               last_in_frame;
    logic        [6:0]  external_faults;
    logic               standalone;
    logic               torque_free;
  } sample_t;

  typedef struct packed {
    logic [FLAG_W-1:0] fault_flags;
    logic [1:0]        severity;
  } report_t;

  typedef struct packed {
    logic        [15:0] position_jump_limit;
    logic        [14:0] velocity_limit;
    logic        [14:0] torque_limit;
    logic signed [15:0] shoulder_min;
    logic signed [15:0] shoulder_max;
    logic signed [15:0] elbow_min;
    logic signed [15:0] elbow_max;
    logic        [15:0] collision_delta;
  } cfg_t;

  // Classified sample as it travels from the front end to the back end
  typedef struct packed {
    logic [2:0]         joint;
    logic               joint_ok;   // joint has history storage
    logic               check;      // checks not bypassed
    logic               arm;
    logic               shoulder;
    logic               startup;
    logic               temp_pos;   // link alive
    logic signed [15:0] position;
    logic signed [15:0] torque;
    logic               vel_hit;
    logic               trq_hit;
    logic               last_in_frame;
    logic               estop;
    logic               comm;       // already masked in standalone mode
    logic               algo;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Absolute value of a 16-bit signed number; -32768 maps to 32768
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? 16'(-v) : 16'(v);
    return r;
  endfunction

  // Absolute value of a 17-bit signed difference
  function automatic logic [16:0] mag17(input logic signed [16:0] v);
    logic [16:0] r;
    r = v[16] ? 17'(-v) : 17'(v);
    return r;
  endfunction

endpackage

>>> hw/rtl/jlfm_front.sv
// Front end: classify an incoming joint sample and check velocity and torque.
module jlfm_front #(
  parameter int JOINTS = jlfm_pkg::JOINTS_DEF
) (
  input  jlfm_pkg::sample_t sample,
  input  jlfm_pkg::cfg_t    cfg,
  output jlfm_pkg::cmd_t    cmd
);

  always_comb begin
    cmd.joint         = sample.joint;
    cmd.joint_ok      = (32'(sample.joint) < JOINTS);
    cmd.check         = !(sample.standalone && sample.torque_free);
    cmd.arm           = (sample.joint >= jlfm_pkg::FIRST_ARM);
    cmd.shoulder      = !sample.joint[0];
    cmd.startup       = sample.startup_window;
    cmd.temp_pos      = (sample.temperature > 8'sd0);
    cmd.position      = sample.position;
    cmd.torque        = sample.torque;
    cmd.vel_hit       = jlfm_pkg::mag16(sample.velocity) > {1'b0, cfg.velocity_limit};
    cmd.trq_hit       = jlfm_pkg::mag16(sample.torque) > {1'b0, cfg.torque_limit};
    cmd.last_in_frame = sample.last_in_frame;
    // mask comm bits in standalone mode
    cmd.estop         = sample.external_faults[0];
    cmd.comm          = (|sample.external_faults[3:1]) && !sample.standalone;
    cmd.algo          = |sample.external_faults[6:4];
  end

endmodule

>>> hw/rtl/jlfm_queue.sv
// Short queue of classified samples between front end and back end.
module jlfm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jlfm_pkg::cmd_t     wdata,
  input  logic               pop,
  output jlfm_pkg::cmd_t     rdata,
  output jlfm_pkg::q_stat_t  stat
);

  localparam int DEPTH = jlfm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jlfm_pkg::cmd_t entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign rdata      = entry[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= wdata;
        wr_ptr        <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/jlfm_back.sv
// Back end: history checks, frame flag gathering and the report register.
module jlfm_back #(
  parameter int JOINTS = jlfm_pkg::JOINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  jlfm_pkg::cmd_t    cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  jlfm_pkg::cfg_t    cfg,
  output logic              report_valid,
  input  logic              report_ready,
  output jlfm_pkg::report_t report
);

  localparam int IDX_W = $clog2(JOINTS);

  logic signed [15:0] prev_pos [JOINTS];
  logic signed [15:0] prev_trq [JOINTS];
  logic [jlfm_pkg::FLAG_W-1:0] frame_flags;

  logic [IDX_W-1:0]            idx;
  logic signed [15:0]          hist_pos;
  logic signed [15:0]          hist_trq;
  logic                        skip;
  logic signed [15:0]          lo;
  logic signed [15:0]          hi;
  logic [jlfm_pkg::FLAG_W-1:0] hits;
  logic [jlfm_pkg::FLAG_W-1:0] flags_total;
  jlfm_pkg::level_t            level;

  assign idx      = IDX_W'(cmd.joint);
  assign hist_pos = cmd.joint_ok ? prev_pos[idx] : '0;
  assign hist_trq = cmd.joint_ok ? prev_trq[idx] : '0;
  // a report waiting in the output register only blocks the next frame end
  assign cmd_pop  = cmd_valid && (!cmd.last_in_frame || !report_valid || report_ready);

  always_comb begin
    skip = cmd.startup || ((hist_pos == 16'sd0) && cmd.temp_pos);
    lo   = cmd.shoulder ? cfg.shoulder_min : cfg.elbow_min;
    hi   = cmd.shoulder ? cfg.shoulder_max : cfg.elbow_max;
    hits = '0;
    hits[jlfm_pkg::FLAG_JUMP] = !skip && (jlfm_pkg::mag17(
        17'({cmd.position[15], cmd.position}) - 17'({hist_pos[15], hist_pos}))
        > {1'b0, cfg.position_jump_limit});
    hits[jlfm_pkg::FLAG_VEL]    = cmd.vel_hit;
    hits[jlfm_pkg::FLAG_TORQUE] = cmd.trq_hit;
    hits[jlfm_pkg::FLAG_SOFT]   = cmd.arm && !skip &&
        ((cmd.position > hi) || (cmd.position < lo));
    hits[jlfm_pkg::FLAG_COLLIDE] = cmd.arm && !skip && (jlfm_pkg::mag17(
        17'({cmd.torque[15], cmd.torque}) - 17'({hist_trq[15], hist_trq}))
        > {1'b0, cfg.collision_delta});
    if (!(cmd.joint_ok && cmd.check)) begin
      hits = '0;
    end
    flags_total = frame_flags | hits;
    if (cmd.estop) begin
      level = jlfm_pkg::LEVEL_ESTOP;
    end else if (cmd.comm) begin
      level = jlfm_pkg::LEVEL_LATCH;
    end else if ((|flags_total) || cmd.algo) begin
      level = jlfm_pkg::LEVEL_WARN;
    end else begin
      level = jlfm_pkg::LEVEL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_flags  <= '0;
      report_valid <= 1'b0;
      for (int i = 0; i < JOINTS; i++) begin
        prev_pos[i] <= '0;
        prev_trq[i] <= '0;
      end
    end else begin
      if (cmd_pop && cmd.last_in_frame) begin
        report_valid <= 1'b1;
      end else if (report_ready) begin
        report_valid <= 1'b0;
      end
      if (cmd_pop) begin
        if (cmd.joint_ok) begin
          prev_pos[idx] <= cmd.position;
          prev_trq[idx] <= cmd.torque;
        end
        if (cmd.last_in_frame) begin
          frame_flags        <= '0;
          report.fault_flags <= flags_total;
          report.severity    <= level;
        end else begin
          frame_flags <= flags_total;
        end
      end
    end
  end

endmodule

>>> hw/rtl/joint_limit_fault_monitor.sv
// Top level of the joint limit fault monitor: config registers, front, queue, back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   sample   | sample_valid/sample_ready | jlfm_pkg::sample_t, one joint
//   report   | report_valid/report_ready | jlfm_pkg::report_t, per frame
//   cfg      | cfg_valid/cfg_ready       | cfg_index (3b), cfg_data (16b)
//
// One sample per cycle sustained while no report stalls. A sample is classified
// and pushed into a two-entry queue in the cycle it transfers; the back end pops
// one entry per cycle unless a stalled report holds a frame end, reading and
// writing the per-joint history in that same cycle, and a frame end lands in the
// report register at the edge that pops it. Report valid is set at that edge too.
// Reset is synchronous: history, gathered flags and config registers return
// to their reset values. A stalled report blocks the queue head only when that
// head ends a frame; samples ahead of it drain, samples behind it wait, and the
// input stalls once both queue entries are taken.
module joint_limit_fault_monitor #(
  parameter int JOINTS = jlfm_pkg::JOINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  jlfm_pkg::sample_t                   sample,
  output logic                                report_valid,
  input  logic                                report_ready,
  output jlfm_pkg::report_t                   report,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jlfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jlfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "joint_limit_fault_monitor_assert.svh"

  jlfm_pkg::cfg_t    cfg;
  jlfm_pkg::cmd_t    front_cmd;
  jlfm_pkg::cmd_t    q_head;
  jlfm_pkg::q_stat_t q_stat;
  logic              q_push;
  logic              q_pop;
  logic              report_flagged;
  logic              report_raised;

  // Config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_jump_limit <= jlfm_pkg::RST_JUMP_LIMIT;
      cfg.velocity_limit      <= jlfm_pkg::RST_VEL_LIMIT;
      cfg.torque_limit        <= jlfm_pkg::RST_TORQUE_LIMIT;
      cfg.shoulder_min        <= jlfm_pkg::RST_SHOULDER_MIN;
      cfg.shoulder_max        <= jlfm_pkg::RST_SHOULDER_MAX;
      cfg.elbow_min           <= jlfm_pkg::RST_ELBOW_MIN;
      cfg.elbow_max           <= jlfm_pkg::RST_ELBOW_MAX;
      cfg.collision_delta     <= jlfm_pkg::RST_COLLISION;
    end else if (cfg_valid && cfg_ready) begin
      unique case (jlfm_pkg::cfg_reg_t'(cfg_index))
        jlfm_pkg::REG_JUMP_LIMIT:   cfg.position_jump_limit <= cfg_data;
        jlfm_pkg::REG_VEL_LIMIT:    cfg.velocity_limit      <= cfg_data[14:0];
        jlfm_pkg::REG_TORQUE_LIMIT: cfg.torque_limit        <= cfg_data[14:0];
        jlfm_pkg::REG_SHOULDER_MIN: cfg.shoulder_min        <= cfg_data;
        jlfm_pkg::REG_SHOULDER_MAX: cfg.shoulder_max        <= cfg_data;
        jlfm_pkg::REG_ELBOW_MIN:    cfg.elbow_min           <= cfg_data;
        jlfm_pkg::REG_ELBOW_MAX:    cfg.elbow_max           <= cfg_data;
        jlfm_pkg::REG_COLLISION:    cfg.collision_delta     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept a sample whenever the queue has room
  assign sample_ready = !q_stat.full;
  assign q_push       = sample_valid && sample_ready;

  jlfm_front #(
    .JOINTS (JOINTS)
  ) u_front (
    .sample (sample),
    .cfg    (cfg),
    .cmd    (front_cmd)
  );

  jlfm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (front_cmd),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (q_stat)
  );

  jlfm_back #(
    .JOINTS (JOINTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (q_head),
    .cmd_valid    (!q_stat.empty),
    .cmd_pop      (q_pop),
    .cfg          (cfg),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report)
  );

  assign report_flagged = report_valid && (report.fault_flags != '0);
  assign report_raised  = (report.severity != jlfm_pkg::LEVEL_NONE);

  // Never push into a full queue
  `JLFM_ASSERT_IMPLIES(a_no_push_full, clk, rst, q_push, !q_stat.full)
  // A popped frame end shows up as a report in the next cycle
  `JLFM_ASSERT_NEXT(a_report_follows, clk, rst, q_pop && q_head.last_in_frame, report_valid)
  // Any gathered flag raises the level above none
  `JLFM_ASSERT_IMPLIES(a_level_covers, clk, rst, report_flagged, report_raised)

endmodule
